[sv/hafr_pkg.sv]
// ----------------------------------------------------------------------------
// hafr_pkg
// Shared types, constants and the hex character decoder for the hex ASCII
// frame receiver.
// ----------------------------------------------------------------------------
package hafr_pkg;

    localparam logic [7:0] START_BYTE = 8'hAC;
    localparam logic [7:0] END_BYTE   = 8'hCC;

    localparam int POS_W = 9;

    localparam logic [1:0] STATUS_GOOD    = 2'd0;
    localparam logic [1:0] STATUS_BAD_XOR = 2'd1;
    localparam logic [1:0] STATUS_BAD_END = 2'd2;

    typedef struct packed {
        logic [7:0] high_char;
        logic [7:0] low_char;
    } char_pair_t;

    typedef struct packed {
        logic [1:0]  frame_status;
        logic [7:0]  frame_class;
        logic [7:0]  frame_sub;
        logic [7:0]  frame_length;
        logic [31:0] leading_payload;
    } frame_result_t;

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [3:0] n;
        n = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            n = 4'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66) begin
            n = 4'(c - 8'h57);
        end
        else if (c >= 8'h41 && c <= 8'h46) begin
            n = 4'(c - 8'h37);
        end
        return n;
    endfunction

endpackage

[sv/hafr_stream_if.sv]
// ----------------------------------------------------------------------------
// hafr_stream_if
// Valid/ready stream channel; one transfer when valid and ready are high.
// ----------------------------------------------------------------------------
interface hafr_stream_if #(
    parameter type payload_t = logic [7:0]
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (
        output valid,
        output payload,
        input  ready
    );

    modport sink (
        input  valid,
        input  payload,
        output ready
    );
endinterface

[sv/hex_ascii_frame_receiver.sv]
// ----------------------------------------------------------------------------
// hex_ascii_frame_receiver
// Decodes pairs of ASCII hex characters to bytes and parses 0xAC-started
// frames: class, sub, length, payload, XOR check, closing byte.
// ----------------------------------------------------------------------------
// One character pair can be transferred every clock cycle. A pair passes
// through an input register and then the decode and parse logic into the
// result register, so a frame result is offered once its closing pair
// leaves the input register. Only the output side can slow the block: while
// a result waits, the pair in the input register holds, and input stalls once
// that register is full.
module hex_ascii_frame_receiver (
    input  logic           clk,
    input  logic           rst_n,
    hafr_stream_if.sink    chars,
    hafr_stream_if.source  frames
);
    import hafr_pkg::*;

    logic              s1_valid_reg;
    char_pair_t        s1_data_reg;
    logic              s1_fire;

    logic              inside_frame_reg,  inside_frame_next;
    logic [POS_W-1:0]  byte_position_reg, byte_position_next;
    logic [7:0]        class_hold_reg,    class_hold_next;
    logic [7:0]        sub_hold_reg,      sub_hold_next;
    logic [7:0]        length_hold_reg,   length_hold_next;
    logic [7:0]        xor_running_reg,   xor_running_next;
    logic              checksum_bad_reg,  checksum_bad_next;
    logic [31:0]       payload_word_reg,  payload_word_next;

    logic              out_valid_reg;
    frame_result_t     out_data_reg;
    logic              result_hit;
    frame_result_t     result_data;

    logic [7:0]        b;
    logic [POS_W-1:0]  check_pos;

    assign s1_fire     = s1_valid_reg && (!out_valid_reg || frames.ready);
    assign chars.ready = !s1_valid_reg || s1_fire;

    assign frames.valid   = out_valid_reg;
    assign frames.payload = out_data_reg;

    assign b         = {hex_nibble(s1_data_reg.high_char), hex_nibble(s1_data_reg.low_char)};
    assign check_pos = POS_W'(3) + POS_W'(length_hold_reg);

    always_comb
    begin
        inside_frame_next  = inside_frame_reg;
        byte_position_next = byte_position_reg;
        class_hold_next    = class_hold_reg;
        sub_hold_next      = sub_hold_reg;
        length_hold_next   = length_hold_reg;
        xor_running_next   = xor_running_reg;
        checksum_bad_next  = checksum_bad_reg;
        payload_word_next  = payload_word_reg;
        result_hit         = 1'b0;
        result_data.frame_status    = STATUS_GOOD;
        result_data.frame_class     = class_hold_reg;
        result_data.frame_sub       = sub_hold_reg;
        result_data.frame_length    = length_hold_reg;
        result_data.leading_payload = payload_word_reg;

        if (!s1_fire) begin
            // hold
        end
        else if (!inside_frame_reg) begin
            if (b == START_BYTE) begin
                inside_frame_next  = 1'b1;
                byte_position_next = '0;
                class_hold_next    = '0;
                sub_hold_next      = '0;
                length_hold_next   = '0;
                xor_running_next   = '0;
                checksum_bad_next  = 1'b0;
                payload_word_next  = '0;
            end
        end
        else begin
            byte_position_next = byte_position_reg + POS_W'(1);
            if (byte_position_reg == POS_W'(0)) begin
                class_hold_next  = b;
                xor_running_next = xor_running_reg ^ b;
            end
            else if (byte_position_reg == POS_W'(1)) begin
                sub_hold_next    = b;
                xor_running_next = xor_running_reg ^ b;
            end
            else if (byte_position_reg == POS_W'(2)) begin
                length_hold_next = b;
                xor_running_next = xor_running_reg ^ b;
            end
            else if (byte_position_reg < check_pos) begin
                xor_running_next = xor_running_reg ^ b;
                case (byte_position_reg)
                    POS_W'(3): payload_word_next = payload_word_reg | {b, 24'd0};
                    POS_W'(4): payload_word_next = payload_word_reg | {8'd0, b, 16'd0};
                    POS_W'(5): payload_word_next = payload_word_reg | {16'd0, b, 8'd0};
                    POS_W'(6): payload_word_next = payload_word_reg | {24'd0, b};
                    default:   payload_word_next = payload_word_reg;
                endcase
            end
            else if (byte_position_reg == check_pos) begin
                checksum_bad_next = (b != xor_running_reg);
            end
            else begin
                result_hit         = 1'b1;
                inside_frame_next  = 1'b0;
                byte_position_next = '0;
                if (b != END_BYTE) begin
                    result_data.frame_status = STATUS_BAD_END;
                end
                else if (checksum_bad_reg) begin
                    result_data.frame_status = STATUS_BAD_XOR;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end
        else if (chars.ready) begin
            s1_valid_reg <= chars.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready) begin
            s1_data_reg <= chars.payload;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            inside_frame_reg  <= 1'b0;
            byte_position_reg <= '0;
            class_hold_reg    <= '0;
            sub_hold_reg      <= '0;
            length_hold_reg   <= '0;
            xor_running_reg   <= '0;
            checksum_bad_reg  <= 1'b0;
            payload_word_reg  <= '0;
            out_valid_reg     <= 1'b0;
        end
        else begin
            inside_frame_reg  <= inside_frame_next;
            byte_position_reg <= byte_position_next;
            class_hold_reg    <= class_hold_next;
            sub_hold_reg      <= sub_hold_next;
            length_hold_reg   <= length_hold_next;
            xor_running_reg   <= xor_running_next;
            checksum_bad_reg  <= checksum_bad_next;
            payload_word_reg  <= payload_word_next;
            if (s1_fire) begin
                out_valid_reg <= result_hit;
            end
            else if (frames.ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && result_hit) begin
            out_data_reg <= result_data;
        end
    end

    a_idle_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !inside_frame_reg |-> byte_position_reg == '0)
        else $error("byte position nonzero while idle");

    a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        inside_frame_reg |-> byte_position_reg <= check_pos + POS_W'(1))
        else $error("byte position past closing position");

    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_data_reg.frame_status != 2'd3)
        else $error("illegal frame status");

    a_result_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && result_hit |=> !inside_frame_reg && out_valid_reg)
        else $error("result did not close frame");

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_fire |=> $stable(inside_frame_reg) && $stable(byte_position_reg))
        else $error("parser state moved without a transfer");

endmodule
